/* rtl/ascii_three_axis_reading_parser_macros.svh */
// Assertion helpers for the reading parser; clk and arst_n come from the using scope.
`ifndef ASCII_THREE_AXIS_READING_PARSER_MACROS_SVH
`define ASCII_THREE_AXIS_READING_PARSER_MACROS_SVH

// same-cycle implication
`define ATRP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atrp assertion failed");

// next-cycle implication
`define ATRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atrp assertion failed");

`endif

/* rtl/atrp_pkg.sv */
package atrp_pkg;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam int VALUE_W = 18;
	localparam logic [31:0] MAG_MAX = 32'd131071;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		CC_OTHER,
		CC_DIGIT,
		CC_NEWLINE,
		CC_EQUALS,
		CC_DOT,
		CC_MINUS,
		CC_COMMA
	} char_class_t;

	typedef struct packed {
		logic                       valid;
		logic [1:0]                 axis;
		logic signed [VALUE_W-1:0]  value;
		logic                       last;
	} atrp_result_t;

	function automatic int pow10(input int n);
		int p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cc;
		unique case (c)
			CH_NEWLINE: cc = CC_NEWLINE;
			CH_EQUALS:  cc = CC_EQUALS;
			CH_DOT:     cc = CC_DOT;
			CH_MINUS:   cc = CC_MINUS;
			CH_COMMA:   cc = CC_COMMA;
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					cc = CC_DIGIT;
				else
					cc = CC_OTHER;
			end
		endcase
		return cc;
	endfunction

endpackage

/* rtl/atrp_parse_core.sv */
module atrp_parse_core
	import atrp_pkg::*;
#(
	parameter int INT_DIGITS  = 3,
	parameter int FRAC_DIGITS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [7:0]   char_in,
	output atrp_result_t res
);

	localparam int INT_W  = $clog2(pow10(INT_DIGITS));
	localparam int FRAC_W = $clog2(pow10(FRAC_DIGITS));
	localparam int MAG_W  = $clog2(pow10(INT_DIGITS + FRAC_DIGITS));
	localparam int CNT_W  = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
	localparam int P_TOP  = pow10(INT_DIGITS - 1);
	localparam int P_FRAC = pow10(FRAC_DIGITS);

	phase_t             phase_q, phase_d;
	logic [1:0]         axis_q, axis_d;
	logic               neg_q, neg_d;
	logic [3:0]         dig_q [INT_DIGITS];
	logic [3:0]         dig_d [INT_DIGITS];
	logic [INT_W-1:0]   int_bin_q, int_bin_d;
	logic [MAG_W-1:0]   int_scaled_q, int_scaled_d;
	logic [FRAC_W-1:0]  frac_q, frac_d;
	logic [CNT_W-1:0]   fcnt_q, fcnt_d;

	char_class_t        cc;
	logic [3:0]         digit;
	logic               emit;
	logic               clr;
	logic [INT_W+3:0]   int_drop;
	logic [INT_W+3:0]   int_next;
	logic [FRAC_W+3:0]  frac_next;
	logic [MAG_W:0]     mag;
	logic [31:0]        mag_ext;
	logic [16:0]        mag_sat;

	assign cc    = classify(char_in);
	assign digit = char_in[3:0];
	assign emit  = (phase_q == PH_FRAC) && (cc == CC_DIGIT) &&
		(fcnt_q == CNT_W'(FRAC_DIGITS - 1));

	// oldest digit drops off the top before the shift
	assign int_drop  = (INT_W+4)'(int_bin_q) -
		(INT_W+4)'(dig_q[INT_DIGITS-1]) * (INT_W+4)'(P_TOP);
	assign int_next  = int_drop * (INT_W+4)'(10) + (INT_W+4)'(digit);
	assign frac_next = (FRAC_W+4)'(frac_q) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);

	assign mag     = (MAG_W+1)'(int_scaled_q) + (MAG_W+1)'(frac_next);
	assign mag_ext = 32'(mag);
	assign mag_sat = (mag_ext > MAG_MAX) ? 17'(MAG_MAX) : 17'(mag_ext);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (cc == CC_NEWLINE) begin
			phase_d = PH_IDLE;
		end else if (cc == CC_EQUALS) begin
			phase_d = PH_INT;
		end else begin
			unique case (phase_q)
				PH_INT: begin
					if (cc == CC_DOT)
						phase_d = PH_FRAC;
				end
				PH_FRAC: begin
					if (cc == CC_COMMA)
						phase_d = PH_INT;
					else if (emit)
						phase_d = (axis_q == AX_Z) ? PH_DONE : PH_INT;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		axis_d       = axis_q;
		neg_d        = neg_q;
		dig_d        = dig_q;
		int_bin_d    = int_bin_q;
		int_scaled_d = int_scaled_q;
		frac_d       = frac_q;
		fcnt_d       = fcnt_q;
		clr = (cc == CC_NEWLINE) || (cc == CC_EQUALS) || emit ||
			((cc == CC_COMMA) && (phase_q == PH_INT || phase_q == PH_FRAC));

		if (phase_q == PH_INT) begin
			case (cc)
				CC_DIGIT: begin
					for (int i = INT_DIGITS - 1; i > 0; i--)
						dig_d[i] = dig_q[i-1];
					dig_d[0]  = digit;
					int_bin_d = INT_W'(int_next);
				end
				CC_MINUS: neg_d = 1'b1;
				CC_DOT: begin
					frac_d       = '0;
					fcnt_d       = '0;
					int_scaled_d = MAG_W'(int_bin_q) * MAG_W'(P_FRAC);
				end
				default: ;
			endcase
		end else if (phase_q == PH_FRAC && cc == CC_DIGIT) begin
			frac_d = FRAC_W'(frac_next);
			fcnt_d = fcnt_q + CNT_W'(1);
		end

		if (cc == CC_NEWLINE || cc == CC_EQUALS)
			axis_d = AX_X;
		else if (emit && axis_q != AX_Z)
			axis_d = axis_q + 2'd1;

		if (clr) begin
			neg_d     = 1'b0;
			int_bin_d = '0;
			frac_d    = '0;
			fcnt_d    = '0;
			for (int i = 0; i < INT_DIGITS; i++)
				dig_d[i] = '0;
		end

		res.valid = emit;
		res.axis  = axis_q;
		res.last  = (axis_q == AX_Z);
		res.value = neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			axis_q       <= AX_X;
			neg_q        <= 1'b0;
			int_bin_q    <= '0;
			int_scaled_q <= '0;
			frac_q       <= '0;
			fcnt_q       <= '0;
			for (int i = 0; i < INT_DIGITS; i++)
				dig_q[i] <= '0;
		end else if (en) begin
			phase_q      <= phase_d;
			axis_q       <= axis_d;
			neg_q        <= neg_d;
			int_bin_q    <= int_bin_d;
			int_scaled_q <= int_scaled_d;
			frac_q       <= frac_d;
			fcnt_q       <= fcnt_d;
			dig_q        <= dig_d;
		end
	end

endmodule

/* rtl/ascii_three_axis_reading_parser.sv */
// A result beat is raised on m_tvalid once the byte that completes it has passed the
// input register and then the parse state update into the output register.
// Throughput: one byte per cycle unless a result is held on m_tready, set by the parse state update.
// A result waiting on m_tready holds the pipeline only when the next byte also yields one.
// Reset (arst_n low, async) returns the parser to idle with all accumulators cleared.
`include "ascii_three_axis_reading_parser_macros.svh"

module ascii_three_axis_reading_parser
	import atrp_pkg::*;
#(
	parameter int INT_DIGITS  = 3,
	parameter int FRAC_DIGITS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] axis_index, [19:2] value_hundredths, [23:20] zero
	output logic        m_tlast    // last_axis
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         advance;
	logic         out_free;
	atrp_result_t res;

	logic         m_valid_q;
	logic [1:0]   axis_q;
	logic [VALUE_W-1:0] value_q;
	logic         last_q;

	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	atrp_parse_core #(
		.INT_DIGITS  (INT_DIGITS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.char_in (char_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			char_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			axis_q  <= res.axis;
			value_q <= res.value;
			last_q  <= res.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, value_q, axis_q};
	assign m_tlast  = last_q;

	`ATRP_ASSERT_IMPLY(a_last_marks_z, m_valid_q, last_q == (axis_q == AX_Z))
	`ATRP_ASSERT_IMPLY(a_axis_in_range, m_valid_q, axis_q != 2'd3)
	`ATRP_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(char_s1))
	`ATRP_ASSERT_IMPLY(a_no_result_overrun, advance && res.valid, out_free)

endmodule
